@@ rtl/core/pcss_pkg.sv @@
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types and character constants for the Python comment/string stripper.
// ----------------------------------------------------------------------------
package pcss_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2
  } doc_kind_t;

  typedef struct packed {
    doc_kind_t   docstring_kind;
    logic        single_open;
    logic [1:0]  single_run;
    logic        double_open;
    logic [1:0]  double_run;
    logic [1:0]  blank_run;
    logic        escape_pending;
    logic        in_comment;
    logic        skip_next;
    logic [7:0]  last_emitted;
    logic [7:0]  prev_input;
  } state_t;

  localparam state_t STATE_RESET = '{
    docstring_kind: KIND_NONE,
    single_open:    1'b0,
    single_run:     2'd0,
    double_open:    1'b0,
    double_run:     2'd0,
    blank_run:      2'd0,
    escape_pending: 1'b0,
    in_comment:     1'b0,
    skip_next:      1'b0,
    last_emitted:   CH_SPACE,
    prev_input:     8'h00
  };

  // Result of one byte step, handed to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       kept;
    logic       last;
  } result_t;

endpackage

@@ rtl/core/pcss_step.sv @@
// ----------------------------------------------------------------------------
// pcss_step
// Combinational next-state and result logic for one source byte.
// ----------------------------------------------------------------------------
module pcss_step (
  input  pcss_pkg::state_t  state,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output pcss_pkg::state_t  state_next,
  output pcss_pkg::result_t result
);

  // Quote character handling; is_dbl selects which quote kind b is.
  function automatic pcss_pkg::state_t quote_event(pcss_pkg::state_t s, logic [7:0] b,
                                                   logic is_dbl);
    pcss_pkg::state_t    r;
    logic                own;
    logic                oth;
    logic [1:0]          run;
    pcss_pkg::doc_kind_t kind;
    r    = s;
    own  = is_dbl ? s.double_open : s.single_open;
    oth  = is_dbl ? s.single_open : s.double_open;
    run  = is_dbl ? s.double_run  : s.single_run;
    kind = is_dbl ? pcss_pkg::KIND_DOUBLE : pcss_pkg::KIND_SINGLE;
    if (s.docstring_kind != pcss_pkg::KIND_NONE) begin
      if (run == 2'd3) begin
        run = 2'd2;
      end else if (s.prev_input == b) begin
        run = run - 2'd1;
      end else begin
        run = 2'd3;
      end
      if (run != 2'd0) begin
        r.docstring_kind = kind;
      end else begin
        r.docstring_kind = pcss_pkg::KIND_NONE;
        r.skip_next = 1'b1;
      end
    end else begin
      if (run == 2'd0 && !(own || oth)) begin
        run = 2'd1;
      end else if (s.prev_input == b && run != 2'd3) begin
        run = run + 2'd1;
      end
      r.docstring_kind = (run == 2'd3) ? kind : pcss_pkg::KIND_NONE;
      if (r.docstring_kind != pcss_pkg::KIND_NONE) begin
        own = 1'b0;
        oth = 1'b0;
        r.skip_next = 1'b1;
      end else if (!oth && !s.in_comment) begin
        if (own) begin
          if (!s.escape_pending) begin
            own = 1'b0;
            r.skip_next = 1'b1;
          end
        end else begin
          own = 1'b1;
        end
      end
    end
    if (is_dbl) begin
      r.double_open = own;
      r.single_open = oth;
      r.double_run  = run;
    end else begin
      r.single_open = own;
      r.double_open = oth;
      r.single_run  = run;
    end
    return r;
  endfunction

  pcss_pkg::state_t n;
  logic             emit;
  logic             active_now;
  logic             active_next;

  assign active_now = state.single_open || state.double_open ||
                      state.docstring_kind != pcss_pkg::KIND_NONE;

  always_comb begin
    n           = state;
    n.skip_next = 1'b0;
    emit        = 1'b0;
    active_next = 1'b0;
    if (!state.in_comment && !active_now && !state.escape_pending &&
        in_byte == pcss_pkg::CH_HASH) begin
      n.in_comment = 1'b1;
      n.blank_run  = 2'd0;
    end else if (state.in_comment && in_byte != pcss_pkg::CH_NL) begin
      // comment text: dropped; only prev_input is updated
    end else begin
      case (in_byte)
        pcss_pkg::CH_NL: begin
          if (state.last_emitted == pcss_pkg::CH_NL) n.skip_next = 1'b1;
          n.in_comment = 1'b0;
          n.blank_run  = 2'd0;
        end
        pcss_pkg::CH_DQUOTE: begin
          if (state.docstring_kind != pcss_pkg::KIND_SINGLE)
            n = quote_event(n, in_byte, 1'b1);
          n.blank_run = 2'd0;
        end
        pcss_pkg::CH_SQUOTE: begin
          if (state.docstring_kind != pcss_pkg::KIND_DOUBLE)
            n = quote_event(n, in_byte, 1'b0);
          n.blank_run = 2'd0;
        end
        pcss_pkg::CH_TAB, pcss_pkg::CH_SPACE: begin
          if (state.last_emitted == pcss_pkg::CH_NL) begin
            n.skip_next = 1'b1;
          end else if (state.blank_run != 2'd2) begin
            n.blank_run = state.blank_run + 2'd1;
          end
        end
        default: begin
          n.blank_run = 2'd0;
        end
      endcase

      // run counters follow the docstring kind after this byte
      if (n.docstring_kind == pcss_pkg::KIND_SINGLE) begin
        if (n.single_run != 2'd3 && in_byte != pcss_pkg::CH_SQUOTE) n.single_run = 2'd3;
        n.double_run = 2'd0;
      end else if (n.docstring_kind == pcss_pkg::KIND_DOUBLE) begin
        if (n.double_run != 2'd3 && in_byte != pcss_pkg::CH_DQUOTE) n.double_run = 2'd3;
        n.single_run = 2'd0;
      end else begin
        if (in_byte != pcss_pkg::CH_SQUOTE) n.single_run = 2'd0;
        if (in_byte != pcss_pkg::CH_DQUOTE) n.double_run = 2'd0;
      end

      active_next = n.single_open || n.double_open ||
                    n.docstring_kind != pcss_pkg::KIND_NONE;
      if (n.skip_next) begin
        n.skip_next = 1'b0;
      end else if (!active_next && n.blank_run != 2'd2) begin
        emit = 1'b1;
      end

      n.escape_pending = (in_byte == pcss_pkg::CH_BSLASH) ? !state.escape_pending : 1'b0;
    end

    n.prev_input = in_byte;
    if (emit) n.last_emitted = in_byte;

    state_next   = end_of_text ? pcss_pkg::STATE_RESET : n;
    result.valid = emit || end_of_text;
    result.data  = emit ? in_byte : 8'h00;
    result.kept  = emit;
    result.last  = end_of_text;
  end

endmodule

@@ rtl/core/python_comment_string_stripper_unit.sv @@
// ----------------------------------------------------------------------------
// python_comment_string_stripper_unit
// Strips comments, strings and docstrings from a Python byte stream and
// squeezes blanks and blank lines.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser     | tlast
//  s_      | in  | [7:0] in_byte  | -         | end_of_text
//  m_      | out | [7:0] out_byte | byte_kept | end_mark
//
// One byte per cycle while s_tready is high; a byte's state update and result are
// computed while it is offered and written to the output register at the
// accepting edge, so a kept byte or end mark shows on m_ in the cycle after acceptance.
// s_tready drops only while the output register is full and m_tready is low.
// rst clears the parse state and empties the output register.
// A transaction with tlast always gives a result and returns the state to reset.
module python_comment_string_stripper_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] byte_kept
  output logic       m_tlast
);

  pcss_pkg::state_t  state;
  pcss_pkg::state_t  state_next;
  pcss_pkg::result_t result;
  logic              accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pcss_step u_step (
    .state       (state),
    .in_byte     (s_tdata),
    .end_of_text (s_tlast),
    .state_next  (state_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcss_pkg::STATE_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept && result.valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result.data;
        m_tuser  <= result.kept;
        m_tlast  <= result.last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/pcss_checker.sv @@
// ----------------------------------------------------------------------------
// pcss_checker
// Port-level checks for the stripper, bound to the top level.
// ----------------------------------------------------------------------------
module pcss_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // stalled output transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled output changed");

  // input side only waits on a full, stalled output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready mismatch");

  // a dropped-byte result only comes with the end mark, and carries zero
  a_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'h00)
    else $error("empty result without end mark");

  // the final byte always produces a result
  a_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tlast)
    else $error("final byte lost");

endmodule

bind python_comment_string_stripper_unit pcss_checker u_pcss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/python_comment_string_stripper_unit_tb.sv @@
// ----------------------------------------------------------------------------
// python_comment_string_stripper_unit_tb
// Self-checking bench for the Python comment/string stripper. A directed
// block covers blank squeezing, comments, docstrings, escapes and end-flag
// handling. Random buffers of Python-like tokens and noise bytes follow.
// A scoreboard class tracks the parse state, predicts each output
// transaction and compares it field by field with what the unit sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module python_comment_string_stripper_unit_tb;

  localparam int RANDOM_BYTES = 750;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       fin;
  } strip_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: parse-state tracker plus queue of expected output transactions
  // --------------------------------------------------------------------------
  class strip_scoreboard;
    pcss_pkg::doc_kind_t doc_kind;
    bit                  sq_open, dq_open;
    bit [1:0]            sq_run, dq_run, blanks;
    bit                  esc, in_cmt, skip;
    bit [7:0]            last_out, prev_byte;
    strip_result_t       expected_q[$];
    int                  n_in, n_out, n_kept, n_final, errors;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      doc_kind  = pcss_pkg::KIND_NONE;
      sq_open   = 0;
      dq_open   = 0;
      sq_run    = 0;
      dq_run    = 0;
      blanks    = 0;
      esc       = 0;
      in_cmt    = 0;
      skip      = 0;
      last_out  = pcss_pkg::CH_SPACE;
      prev_byte = 8'h00;
    endfunction

    function bit str_active();
      return sq_open || dq_open || doc_kind != pcss_pkg::KIND_NONE;
    endfunction

    function void quote_step(bit [7:0] b, bit is_dq);
      bit                  own, other;
      bit [1:0]            run;
      pcss_pkg::doc_kind_t kind;
      own   = is_dq ? dq_open : sq_open;
      other = is_dq ? sq_open : dq_open;
      run   = is_dq ? dq_run  : sq_run;
      kind  = is_dq ? pcss_pkg::KIND_DOUBLE : pcss_pkg::KIND_SINGLE;
      if (doc_kind != pcss_pkg::KIND_NONE) begin
        // inside a docstring the run counts down toward the closing triple
        if (run == 2'd3) run = 2'd2;
        else if (prev_byte == b) run = run - 2'd1;
        else run = 2'd3;
        if (run != 0) begin
          doc_kind = kind;
        end else begin
          doc_kind = pcss_pkg::KIND_NONE;
          skip = 1;
        end
      end else begin
        if (run == 0 && !(own || other)) run = 2'd1;
        else if (prev_byte == b && run < 2'd3) run = run + 2'd1;
        doc_kind = (run == 2'd3) ? kind : pcss_pkg::KIND_NONE;
        if (doc_kind != pcss_pkg::KIND_NONE) begin
          own   = 0;
          other = 0;
          skip  = 1;
        end else if (!other && !in_cmt) begin
          if (own) begin
            if (!esc) begin
              own  = 0;
              skip = 1;
            end
          end else begin
            own = 1;
          end
        end
      end
      if (is_dq) begin
        dq_open = own;
        sq_open = other;
        dq_run  = run;
      end else begin
        sq_open = own;
        dq_open = other;
        sq_run  = run;
      end
    endfunction

    // Advance the parse state by one byte; returns 1 if the byte is kept
    function bit strip_step(bit [7:0] b);
      bit emit;
      emit = 0;
      if (!in_cmt && !str_active() && !esc && b == pcss_pkg::CH_HASH) begin
        in_cmt = 1;
        blanks = 0;
      end else if (in_cmt && b != pcss_pkg::CH_NL) begin
        // comment body: dropped; only prev_byte is updated
      end else begin
        case (b)
          pcss_pkg::CH_NL: begin
            if (last_out == pcss_pkg::CH_NL) skip = 1;
            in_cmt = 0;
            blanks = 0;
          end
          pcss_pkg::CH_DQUOTE: begin
            if (doc_kind != pcss_pkg::KIND_SINGLE) quote_step(b, 1'b1);
            blanks = 0;
          end
          pcss_pkg::CH_SQUOTE: begin
            if (doc_kind != pcss_pkg::KIND_DOUBLE) quote_step(b, 1'b0);
            blanks = 0;
          end
          pcss_pkg::CH_TAB, pcss_pkg::CH_SPACE: begin
            if (last_out == pcss_pkg::CH_NL) skip = 1;
            else if (blanks < 2'd2) blanks = blanks + 2'd1;
          end
          default: blanks = 0;
        endcase

        if (doc_kind == pcss_pkg::KIND_SINGLE) begin
          if (sq_run < 2'd3 && b != pcss_pkg::CH_SQUOTE) sq_run = 2'd3;
          dq_run = 0;
        end else if (doc_kind == pcss_pkg::KIND_DOUBLE) begin
          if (dq_run < 2'd3 && b != pcss_pkg::CH_DQUOTE) dq_run = 2'd3;
          sq_run = 0;
        end else begin
          if (sq_run > 0 && b != pcss_pkg::CH_SQUOTE) sq_run = 0;
          if (dq_run > 0 && b != pcss_pkg::CH_DQUOTE) dq_run = 0;
        end

        if (skip) skip = 0;
        else if (!str_active() && blanks < 2'd2) emit = 1;

        esc = (b == pcss_pkg::CH_BSLASH) ? !esc : 1'b0;
      end
      prev_byte = b;
      if (emit) last_out = b;
      return emit;
    endfunction

    function void note_byte(bit [7:0] b, bit fin);
      bit            kept;
      strip_result_t r;
      n_in++;
      kept = strip_step(b);
      if (kept || fin) begin
        r.data = kept ? b : 8'h00;
        r.kept = kept;
        r.fin  = fin;
        expected_q.push_back(r);
      end
      if (fin) clear_state();
    endfunction

    function void check_result(logic [7:0] data, logic kept, logic fin);
      strip_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction data=%02h kept=%0b last=%0b",
                 $time, data, kept, fin);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_out++;
      if (kept === 1'b1) n_kept++;
      if (fin === 1'b1) n_final++;
      if (data !== exp_r.data) begin
        $display("%0t: out_byte mismatch expected %02h actual %02h",
                 $time, exp_r.data, data);
        errors++;
      end
      if (kept !== exp_r.kept) begin
        $display("%0t: byte_kept mismatch expected %0b actual %0b",
                 $time, exp_r.kept, kept);
        errors++;
      end
      if (fin !== exp_r.fin) begin
        $display("%0t: end_mark mismatch expected %0b actual %0b",
                 $time, exp_r.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_tlast  = 1'b0;   // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // [0] byte_kept
  logic       m_tlast;           // end_mark

  python_comment_string_stripper_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  strip_scoreboard sb = new();
  bit              src_gaps = 1'b1;
  bit              sink_stalls = 1'b1;
  int              quiet_cycles = 0;
  int              n_buffers = 0;
  logic [7:0]      src_q[$];

  // Sink side: random back-pressure while sink_stalls is set, else always ready
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= sink_stalls ? ($urandom_range(0, 99) >= 38) : 1'b1;
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (src_gaps && $urandom_range(0, 99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    sb.note_byte(b, fin);
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 63) return pcss_pkg::CH_SPACE;
    if (r < 67) return pcss_pkg::CH_TAB;
    if (r < 72) return pcss_pkg::CH_HASH;
    if (r < 78) return pcss_pkg::CH_BSLASH;
    if (r < 84) return pcss_pkg::CH_SQUOTE;
    if (r < 90) return pcss_pkg::CH_DQUOTE;
    if (r < 94) return pcss_pkg::CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Append one Python-like token (or some noise) to the source buffer
  task automatic add_token();
    int         kind;
    logic [7:0] q, c;
    kind = $urandom_range(0, 99);
    q = $urandom_range(0, 1) ? pcss_pkg::CH_SQUOTE : pcss_pkg::CH_DQUOTE;
    if (kind < 24) begin
      repeat ($urandom_range(1, 6)) src_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
    end else if (kind < 36) begin
      repeat ($urandom_range(1, 4))
        src_q.push_back($urandom_range(0, 1) ? pcss_pkg::CH_SPACE : pcss_pkg::CH_TAB);
    end else if (kind < 46) begin
      repeat ($urandom_range(1, 3)) src_q.push_back(pcss_pkg::CH_NL);
    end else if (kind < 56) begin
      src_q.push_back(pcss_pkg::CH_HASH);
      repeat ($urandom_range(0, 8)) src_q.push_back(text_char());
      src_q.push_back(pcss_pkg::CH_NL);
    end else if (kind < 70) begin
      src_q.push_back(q);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          src_q.push_back(pcss_pkg::CH_BSLASH);
          src_q.push_back(text_char());
        end else begin
          c = text_char();
          // mostly keep the string open until the closing quote
          if (c == q && $urandom_range(0, 3) != 0) c = 8'h2E;
          src_q.push_back(c);
        end
      end
      src_q.push_back(q);
    end else if (kind < 84) begin
      repeat (3) src_q.push_back(q);
      repeat ($urandom_range(0, 10)) begin
        c = text_char();
        src_q.push_back(c);
        if (c == q && $urandom_range(0, 1)) src_q.push_back(q);
      end
      repeat (3) src_q.push_back(q);
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 3)) src_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3))
        src_q.push_back($urandom_range(0, 2) ? q : pcss_pkg::CH_BSLASH);
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // blank squeeze, comment, repeated newline, leading blank
    send_text("a \t#\n\n c", 1'b1);
    // double-quote docstring with a single quote inside
    send_text("\"\"\"'\"\"\"x", 1'b1);
    // escaped quote in a string; final byte dropped inside a comment
    send_text("'\\'b'#", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    while (sb.n_in < 24 + RANDOM_BYTES) begin
      n_buffers++;
      src_gaps    = !(n_buffers >= 6 && n_buffers < 11);
      sink_stalls = src_gaps;
      src_q.delete();
      target = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(8, 60));
      while (src_q.size() < target) add_token();
      foreach (src_q[i]) send_byte(src_q[i], i == src_q.size() - 1);
    end
    s_tvalid <= 1'b0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d bytes in %0d random buffers plus directed text;",
             sb.n_in, n_buffers);
    $display("checked %0d output transactions (%0d kept bytes, %0d end marks).",
             sb.n_out, sb.n_kept, sb.n_final);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pcss_pkg.sv
rtl/core/pcss_step.sv
rtl/core/python_comment_string_stripper_unit.sv
rtl/core/pcss_checker.sv
tb/python_comment_string_stripper_unit_tb.sv
